### rtl/lppd_pkg.sv
// Shared types and constants for the length-prefixed packet deframer.
package lppd_pkg;

	localparam int unsigned HeaderBytes = 4;
	localparam logic [15:0] MaxLenReset = 16'd384;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_TOO_LONG = 2'd2,
		KIND_NO_ROOM  = 2'd3
	} kind_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] payload_byte;
		logic       last_byte;
	} result_t;

endpackage

### rtl/length_prefixed_packet_deframer.sv
// Top level of the length-prefixed packet deframer.
//
// Bytes from the serial link arrive on the input channel (in_valid/in_ready,
// rx_byte, room_available), one per transaction. Each packet opens with a
// four-byte header: a little-endian 16-bit length, a channel byte and a
// sender id byte. The fourth header byte samples room_available and checks
// the length against max_payload_length, written through
// max_payload_length_we/max_payload_length_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Results leave on the output channel (out_valid/out_ready, kind,
// payload_byte, last_byte): each payload byte, an empty-packet marker, or a
// drop report; the payload of a dropped packet is swallowed without results.
// An accepted byte waits in the input register, is parsed there and its
// result, if any, is loaded into the output register once that is free, so
// one byte is taken every cycle while the output drains.
// If the receiver stalls, the output register holds and the input register
// fills; in_ready then drops until out_ready returns. Reset clears both
// valid flags and the parser state and restores the length limit to 384.
module length_prefixed_packet_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                max_payload_length_we,
	input  logic [15:0]         max_payload_length_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  logic                room_available,
	output logic                out_valid,
	input  logic                out_ready,
	output lppd_pkg::kind_t     kind,
	output logic [7:0]          payload_byte,
	output logic                last_byte
);
	import lppd_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       room_s1;
	logic       out_free;
	logic       step;
	result_t    result;

	assign out_free = !out_valid || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
			room_s1    <= room_available;
		end
	end

	lppd_parser u_parser (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.max_payload_length_we    (max_payload_length_we),
		.max_payload_length_wdata (max_payload_length_wdata),
		.step                     (step),
		.rx_byte                  (rx_byte_s1),
		.room_available           (room_s1),
		.result                   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= step && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.valid) begin
			kind         <= result.kind;
			payload_byte <= result.payload_byte;
			last_byte    <= result.last_byte;
		end
	end

endmodule

### rtl/lppd_parser.sv
// Header parsing and payload counting state for the deframer.
module lppd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              max_payload_length_we,
	input  logic [15:0]       max_payload_length_wdata,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic              room_available,
	output lppd_pkg::result_t result
);
	import lppd_pkg::*;

	localparam logic [2:0] HdrLast = 3'(HeaderBytes - 1);
	localparam logic [2:0] HdrDone = 3'(HeaderBytes);

	logic [15:0] max_len_q;
	logic [2:0]  header_count_q, header_count_d;
	logic [7:0]  length_low_q, length_low_d;
	logic [15:0] remaining_q, remaining_d;
	logic        discarding_q, discarding_d;

	logic        in_header;
	logic [2:0]  hc_base;
	logic [15:0] length;
	logic [15:0] rem_dec;
	logic        too_long;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxLenReset;
		end else if (max_payload_length_we) begin
			max_len_q <= max_payload_length_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= '0;
			length_low_q   <= '0;
			remaining_q    <= '0;
			discarding_q   <= 1'b0;
		end else if (step) begin
			header_count_q <= header_count_d;
			length_low_q   <= length_low_d;
			remaining_q    <= remaining_d;
			discarding_q   <= discarding_d;
		end
	end

	// A payload phase with nothing left falls back to header byte zero.
	assign in_header = (header_count_q < HdrDone) || (remaining_q == 16'd0);
	assign hc_base   = (header_count_q < HdrDone) ? header_count_q : 3'd0;
	assign length    = (hc_base == 3'd1) ? {rx_byte, length_low_q} : remaining_q;
	assign rem_dec   = remaining_q - 16'd1;
	assign too_long  = length > max_len_q;

	always_comb begin
		header_count_d      = header_count_q;
		length_low_d        = length_low_q;
		remaining_d         = remaining_q;
		discarding_d        = discarding_q;
		result.valid        = 1'b0;
		result.kind         = KIND_PAYLOAD;
		result.payload_byte = 8'd0;
		result.last_byte    = 1'b0;
		if (in_header) begin
			if (hc_base == 3'd0) begin
				length_low_d = rx_byte;
			end
			remaining_d = length;
			if (header_count_q >= HdrDone) begin
				discarding_d = 1'b0;
			end
			if (hc_base != HdrLast) begin
				header_count_d = hc_base + 3'd1;
			end else if (too_long || !room_available) begin
				result.valid = 1'b1;
				result.kind  = too_long ? KIND_TOO_LONG : KIND_NO_ROOM;
				if (length == 16'd0) begin
					header_count_d = 3'd0;
					discarding_d   = 1'b0;
				end else begin
					header_count_d = HdrDone;
					discarding_d   = 1'b1;
				end
			end else begin
				discarding_d = 1'b0;
				if (length == 16'd0) begin
					header_count_d = 3'd0;
					result.valid   = 1'b1;
					result.kind    = KIND_EMPTY;
				end else begin
					header_count_d = HdrDone;
				end
			end
		end else begin
			remaining_d = rem_dec;
			if (rem_dec == 16'd0) begin
				header_count_d = 3'd0;
			end
			if (discarding_q) begin
				if (rem_dec == 16'd0) begin
					discarding_d = 1'b0;
				end
			end else begin
				result.valid        = 1'b1;
				result.kind         = KIND_PAYLOAD;
				result.payload_byte = rx_byte;
				result.last_byte    = (rem_dec == 16'd0);
			end
		end
	end

endmodule

### rtl/lppd_checker.sv
// Port-level checks for the deframer, bound to its top level.
module lppd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input lppd_pkg::kind_t kind,
	input logic [7:0]      payload_byte,
	input logic            last_byte
);
	import lppd_pkg::*;

	// A stalled result must stay put until the receiver takes it.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind)
			&& $stable(payload_byte) && $stable(last_byte))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0 && !last_byte)
		else $error("non-payload result carries data");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> kind == KIND_PAYLOAD)
		else $error("last marker on a non-payload result");

	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (.*);

### tb/tb.sv
// Testbench for the length-prefixed packet deframer: directed and random packets.
`timescale 1ns / 1ps

module tb;
	import lppd_pkg::*;

	localparam int unsigned CycleLimit = 1500000;

	// Predicts deframer results byte by byte and checks the results that leave the block.
	class frame_scoreboard;
		typedef struct {
			kind_t      kind;
			logic [7:0] data;
			logic       last;
		} frame_result_t;

		logic [15:0]   max_len;
		logic [2:0]    hdr_count;
		logic [7:0]    len_low;
		logic [15:0]   remaining;
		logic          skipping;
		frame_result_t expected_results[$];
		int unsigned   errors;

		function new();
			max_len = MaxLenReset;
			hdr_count = '0;
			len_low = '0;
			remaining = '0;
			skipping = 1'b0;
			errors = 0;
		endfunction

		function void push_result(kind_t k, logic [7:0] d, logic l);
			frame_result_t r;
			r.kind = k;
			r.data = d;
			r.last = l;
			expected_results.push_back(r);
		endfunction

		function void header_byte(logic [7:0] b, logic room);
			if (hdr_count == 3'd0) begin
				len_low = b;
			end else if (hdr_count == 3'd1) begin
				remaining = {b, len_low};
			end
			hdr_count = hdr_count + 3'd1;
			if (hdr_count < HeaderBytes)
				return;
			if (remaining > max_len || !room) begin
				if (remaining == 16'd0) begin
					hdr_count = '0;
					skipping = 1'b0;
				end else begin
					skipping = 1'b1;
				end
				push_result((remaining > max_len) ? KIND_TOO_LONG : KIND_NO_ROOM,
					8'd0, 1'b0);
				return;
			end
			skipping = 1'b0;
			if (remaining == 16'd0) begin
				hdr_count = '0;
				push_result(KIND_EMPTY, 8'd0, 1'b0);
			end
		endfunction

		// Called for every accepted input transaction.
		function void take_byte(logic [7:0] b, logic room);
			if (hdr_count < HeaderBytes) begin
				header_byte(b, room);
				return;
			end
			if (remaining == 16'd0) begin
				hdr_count = '0;
				skipping = 1'b0;
				header_byte(b, room);
				return;
			end
			remaining = remaining - 16'd1;
			if (remaining == 16'd0)
				hdr_count = '0;
			if (skipping) begin
				if (remaining == 16'd0)
					skipping = 1'b0;
				return;
			end
			push_result(KIND_PAYLOAD, b, remaining == 16'd0);
		endfunction

		// Called for every accepted output transaction.
		function void match_result(kind_t k, logic [7:0] d, logic l);
			frame_result_t r;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind=%0d byte=%h last=%b", k, d, l);
				return;
			end
			r = expected_results.pop_front();
			if (r.kind !== k || r.data !== d || r.last !== l) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected kind=%0d byte=%h last=%b,",
						" got kind=%0d byte=%h last=%b"},
						r.kind, r.data, r.last, k, d, l);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        max_payload_length_we = 1'b0;
	logic [15:0] max_payload_length_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        room_available = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	kind_t       kind;
	logic [7:0]  payload_byte;
	logic        last_byte;

	frame_scoreboard sb = new();
	logic        in_taken = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned phase_bytes = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_timer = 0;

	length_prefixed_packet_deframer DUT (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.max_payload_length_we   (max_payload_length_we),
		.max_payload_length_wdata(max_payload_length_wdata),
		.in_valid                (in_valid),
		.in_ready                (in_ready),
		.rx_byte                 (rx_byte),
		.room_available          (room_available),
		.out_valid               (out_valid),
		.out_ready               (out_ready),
		.kind                    (kind),
		.payload_byte            (payload_byte),
		.last_byte               (last_byte)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Sample both channels at the rising edge.
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_byte(rx_byte, room_available);
			if (out_valid && out_ready)
				sb.match_result(kind, payload_byte, last_byte);
		end
	end

	// Receiver backpressure: a new stall pattern is drawn whenever stall_timer wraps to zero.
	always @(negedge clk) begin
		if (stall_timer == 0)
			stall_mode = $urandom_range(0, 3);
		stall_timer = (stall_timer + 1) % 64;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((stall_timer % 8) < 3);
		endcase
	end

	// Drives one byte, with random gaps between bursts unless gapless is set.
	task automatic send_byte(input logic [7:0] b, input logic room, input bit gapless);
		int unsigned gap;
		if (!gapless) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				burst_left = $urandom_range(1, 20);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		room_available <= room;
		phase_bytes++;
		do @(negedge clk); while (!in_taken);
	endtask

	// Room is only sampled on the fourth header byte; the other bytes get random room.
	task automatic send_packet(input logic [15:0] len, input logic room, input bit gapless);
		int i;
		send_byte(len[7:0], 1'($urandom_range(0, 1)), gapless);
		send_byte(len[15:8], 1'($urandom_range(0, 1)), gapless);
		send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), gapless);
		send_byte(8'($urandom_range(0, 255)), room, gapless);
		for (i = 0; i < int'(len); i++)
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), gapless);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_max_len(input logic [15:0] value);
		settle();
		max_payload_length_we <= 1'b1;
		max_payload_length_wdata <= value;
		@(negedge clk);
		max_payload_length_we <= 1'b0;
		sb.max_len = value;
	endtask

	function automatic logic [15:0] pick_length(input logic [15:0] lim);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 16'd0;
		if (lim <= 16'd40 && sel == 1)
			return lim;
		if (lim <= 16'd40 && sel == 2)
			return lim + 16'd1;
		return 16'($urandom_range(1, 12));
	endfunction

	logic [15:0] limits[6];
	int          p;

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty packet, empty with no room, one-byte payload and a no-room drop
		// under the reset limit, then a too-long drop under a limit of one and a zero length under a zero limit.
		send_packet(16'd0, 1'b1, 1'b0);
		send_packet(16'd0, 1'b0, 1'b0);
		send_packet(16'd1, 1'b1, 1'b0);
		send_packet(16'd2, 1'b0, 1'b0);
		write_max_len(16'd1);
		send_packet(16'd2, 1'b1, 1'b0);
		write_max_len(16'd0);
		send_packet(16'd0, 1'b1, 1'b0);

		limits[0] = 16'd0;
		limits[1] = 16'd1;
		limits[2] = 16'($urandom_range(2, 30));
		limits[3] = MaxLenReset;
		limits[4] = 16'hFFFF;
		limits[5] = 16'($urandom_range(0, 65535));
		for (p = 0; p < 6; p++) begin
			write_max_len(limits[p]);
			phase_bytes = 0;
			// At the reset limit the two boundary packets fill the whole phase.
			if (limits[p] == MaxLenReset) begin
				send_packet(MaxLenReset, 1'b1, 1'b0);
				send_packet(MaxLenReset + 16'd1, 1'b1, 1'b0);
			end
			while (phase_bytes < 60)
				send_packet(pick_length(limits[p]), $urandom_range(0, 4) != 0, 1'b0);
		end

		settle();
		repeat (8) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### length_prefixed_packet_deframer.f
rtl/lppd_pkg.sv
rtl/lppd_parser.sv
rtl/length_prefixed_packet_deframer.sv
rtl/lppd_checker.sv
tb/tb.sv
